// ----- src/glr_pkg.sv -----
// Shared types, constants and lookup tables for the gray Laplacian run extractor.
package glr_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_W     = 12;
    // Width used to compare column positions against the effective width
    localparam int EW_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 8;

    // Result field widths
    localparam int SEG_ROW_W = 12;
    localparam int SEG_X_W   = 11;
    localparam int SEG_IDX_W = 20;
    localparam logic [SEG_IDX_W-1:0] SEG_IDX_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_PIXEL_FORMAT   = 2'd2,
        REG_EDGE_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        FMT_BGRA   = 1'b0,
        FMT_RGB565 = 1'b1
    } pix_fmt_t;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 12'd2048;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 12'd2048;
    localparam logic [PIX_W-1:0] RST_EDGE_THRESHOLD = 8'd96;
    localparam int               MIN_DIM            = 3;

    // 3x3 window around the output pixel: left, center, right columns
    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] ml;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] tc;
        logic [PIX_W-1:0] mc;
        logic [PIX_W-1:0] bc;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] mr;
        logic [PIX_W-1:0] br;
    } window_t;

    // RGB565 channel expansion tables: v * 255 / 31 and v * 255 / 63, truncating
    typedef logic [31:0][PIX_W-1:0] scale5_tbl_t;
    typedef logic [63:0][PIX_W-1:0] scale6_tbl_t;

    function automatic scale5_tbl_t build_scale5();
        scale5_tbl_t t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic scale6_tbl_t build_scale6();
        scale6_tbl_t t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'((i * 255) / 63);
        end
        return t;
    endfunction

    localparam scale5_tbl_t SCALE5_TBL = build_scale5();
    localparam scale6_tbl_t SCALE6_TBL = build_scale6();

endpackage

// ----- src/glr_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module glr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/glr_gray.sv -----
// Pixel to 8-bit gray conversion for BGRA and RGB565 formats.
module glr_gray (
    input  logic [23:0]             pixel_bits,
    input  glr_pkg::pix_fmt_t       pixel_format,
    output logic [glr_pkg::PIX_W-1:0] gray
);
    import glr_pkg::*;

    logic [PIX_W-1:0] b8;
    logic [PIX_W-1:0] g8;
    logic [PIX_W-1:0] r8;
    logic [15:0]      luma_sum;

    // Channel extraction; RGB565 channels expand through the tables
    always_comb
    begin
        case (pixel_format)
            FMT_BGRA:
            begin
                b8 = pixel_bits[7:0];
                g8 = pixel_bits[15:8];
                r8 = pixel_bits[23:16];
            end
            FMT_RGB565:
            begin
                b8 = SCALE5_TBL[pixel_bits[4:0]];
                g8 = SCALE6_TBL[pixel_bits[10:5]];
                r8 = SCALE5_TBL[pixel_bits[15:11]];
            end
            default:
            begin
                b8 = '0;
                g8 = '0;
                r8 = '0;
            end
        endcase
    end

    // Weighted sum, max 255*256 fits 16 bits
    assign luma_sum = ({8'd0, b8} * 16'd29) + ({8'd0, g8} * 16'd150) + ({8'd0, r8} * 16'd77);
    assign gray     = luma_sum[15:8];

endmodule

// ----- src/glr_edge.sv -----
// 3x3 Laplacian kernel with clamp and threshold, producing the edge flag.
module glr_edge (
    input  glr_pkg::window_t          win,
    input  logic [glr_pkg::PIX_W-1:0] threshold,
    output logic                      edge_hit
);
    import glr_pkg::*;

    logic [9:0]        corner_sum;
    logic [9:0]        side_sum;
    logic [12:0]       pos_sum;
    logic [12:0]       neg_sum;
    logic signed [13:0] lap;
    logic [PIX_W-1:0]  lap_clamped;

    // Corners weigh 1, sides 4, center -20
    assign corner_sum = {2'd0, win.tl} + {2'd0, win.bl} + {2'd0, win.tr} + {2'd0, win.br};
    assign side_sum   = {2'd0, win.tc} + {2'd0, win.ml} + {2'd0, win.mr} + {2'd0, win.bc};
    assign pos_sum    = {3'd0, corner_sum} + {1'b0, side_sum, 2'b00};
    assign neg_sum    = {5'd0, win.mc} * 13'd20;
    assign lap        = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});

    // Clamp to 0..255
    always_comb
    begin
        if (lap < 0)
        begin
            lap_clamped = '0;
        end
        else if (lap > 14'sd255)
        begin
            lap_clamped = '1;
        end
        else
        begin
            lap_clamped = lap[PIX_W-1:0];
        end
    end

    // Below threshold or zero counts as no edge
    assign edge_hit = (lap_clamped >= threshold) && (lap_clamped != '0);

endmodule

// ----- src/gray_laplacian_run_extractor.sv -----
// Top level: gray conversion, line store, Laplacian window and run extraction.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  pixel    | pixel_valid/pixel_stall| pixel_data[31:0]
//  seg      | seg_valid/seg_stall    | seg_row, seg_x_start, seg_x_end, seg_index
//  cfg      | cfg_valid/cfg_ready    | cfg_index[1:0], cfg_data[11:0]
//
// One pixel per clock sustained while no held result is stalled. A pixel is registered at its
// accept edge, and a run it closes is loaded into the output register when the input
// register advances, which a held result with seg_stall high can delay. The line store
// is one RAM read and written once per pixel.
// Reset is asynchronous; the line store is not cleared and holds garbage until
// the first two rows of a frame are written. cfg_ready is always high.
// A held result with seg_stall high keeps the input register from moving, so
// pixel_stall is high whenever that register is occupied meanwhile.
module gray_laplacian_run_extractor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  logic [31:0]                     pixel_data,
    output logic                            seg_valid,
    input  logic                            seg_stall,
    output logic [glr_pkg::SEG_ROW_W-1:0]   seg_row,
    output logic [glr_pkg::SEG_X_W-1:0]     seg_x_start,
    output logic [glr_pkg::SEG_X_W-1:0]     seg_x_end,
    output logic [glr_pkg::SEG_IDX_W-1:0]   seg_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [glr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [glr_pkg::CFG_W-1:0]       cfg_data
);
    import glr_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    pix_fmt_t         pixel_format_reg;
    logic [PIX_W-1:0] edge_threshold_reg;

    // Effective geometry
    logic [EW_W-1:0]  eff_w;
    logic [CFG_W-1:0] eff_h;

    // Front counters for the next accepted pixel
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             fr_last_col;
    logic             fr_last_row;

    // Input register stage
    logic             in_accept;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_adv;
    logic [PIX_W-1:0] gray_in;
    logic [PIX_W-1:0] s1_gray_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    // Line store
    logic [2*PIX_W-1:0] ram_rd_data;
    logic [PIX_W-1:0]   top_px;
    logic [PIX_W-1:0]   mid_px;

    // Window and run state
    logic [PIX_W-1:0]     window_reg [6];
    window_t              win;
    logic                 edge_hit;
    logic                 s1_last_col;
    logic                 s1_last_row;
    logic                 interior;
    logic [COL_W-1:0]     c_col;
    logic                 run_open_reg;
    logic                 run_open_next;
    logic [COL_W-1:0]     run_start_reg;
    logic [COL_W-1:0]     run_start_next;
    logic [SEG_IDX_W-1:0] run_total_reg;
    logic [SEG_IDX_W-1:0] run_total_next;
    logic                 emit;
    logic [COL_W-1:0]     emit_xs;
    logic [COL_W-1:0]     emit_xe;

    // Output register
    logic                 seg_valid_reg;
    logic [SEG_ROW_W-1:0] seg_row_reg;
    logic [SEG_X_W-1:0]   seg_x_start_reg;
    logic [SEG_X_W-1:0]   seg_x_end_reg;
    logic [SEG_IDX_W-1:0] seg_index_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
            pixel_format_reg   <= FMT_BGRA;
            edge_threshold_reg <= RST_EDGE_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                REG_PIXEL_FORMAT:   pixel_format_reg   <= pix_fmt_t'(cfg_data[0]);
                REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[PIX_W-1:0];
                default:            ;
            endcase
        end
    end

    // Width limited to 3..MAX_WIDTH, height at least 3
    always_comb
    begin
        if (EW_W'(image_width_reg) < EW_W'(MIN_DIM))
        begin
            eff_w = EW_W'(MIN_DIM);
        end
        else if (EW_W'(image_width_reg) > EW_W'(MAX_WIDTH))
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(image_width_reg);
        end
    end

    assign eff_h = (image_height_reg < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : image_height_reg;

    // Handshake: stage 1 moves on when the output slot is free
    assign s1_adv      = s1_valid_reg && (!seg_valid_reg || !seg_stall);
    assign pixel_stall = s1_valid_reg && !s1_adv;
    assign in_accept   = pixel_valid && !pixel_stall;

    // Front raster counters
    assign fr_last_col = (EW_W'(col_reg) + EW_W'(1)) >= eff_w;
    assign fr_last_row = ({1'b0, row_reg} + 13'd1) >= {1'b0, eff_h};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (fr_last_col)
            begin
                col_next = '0;
                row_next = fr_last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Gray conversion ahead of the input register
    glr_gray u_gray (
        .pixel_bits   (pixel_data[23:0]),
        .pixel_format (pixel_format_reg),
        .gray         (gray_in)
    );

    // Input register stage
    assign s1_valid_next = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_gray_reg <= gray_in;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
        end
    end

    // Line store: each entry holds {row y-2, row y-1} for its column
    glr_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_px, s1_gray_reg}),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    assign top_px = ram_rd_data[2*PIX_W-1:PIX_W];
    assign mid_px = ram_rd_data[PIX_W-1:0];

    // Window assembly: two stored columns plus the current one
    assign win.tl = window_reg[0];
    assign win.ml = window_reg[1];
    assign win.bl = window_reg[2];
    assign win.tc = window_reg[3];
    assign win.mc = window_reg[4];
    assign win.bc = window_reg[5];
    assign win.tr = top_px;
    assign win.mr = mid_px;
    assign win.br = s1_gray_reg;

    glr_edge u_edge (
        .win       (win),
        .threshold (edge_threshold_reg),
        .edge_hit  (edge_hit)
    );

    // Run tracking for the pixel one row up and one column left
    assign s1_last_col = (EW_W'(s1_col_reg) + EW_W'(1)) >= eff_w;
    assign s1_last_row = ({1'b0, s1_row_reg} + 13'd1) >= {1'b0, eff_h};
    assign interior    = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));
    assign c_col       = s1_col_reg - COL_W'(1);

    always_comb
    begin
        emit           = 1'b0;
        emit_xs        = run_start_reg;
        emit_xe        = c_col;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        run_total_next = run_total_reg;
        if (interior)
        begin
            if (edge_hit)
            begin
                if (!run_open_reg)
                begin
                    run_start_next = c_col;
                    emit_xs        = c_col;
                end
                run_open_next = 1'b1;
                if (s1_last_col)
                begin
                    emit          = 1'b1;
                    run_open_next = 1'b0;
                end
            end
            else if (run_open_reg)
            begin
                emit          = 1'b1;
                emit_xe       = c_col - COL_W'(1);
                run_open_next = 1'b0;
            end
        end
        if (emit && (run_total_reg != SEG_IDX_MAX))
        begin
            run_total_next = run_total_reg + SEG_IDX_W'(1);
        end
        if (s1_last_col)
        begin
            run_open_next = 1'b0;
            if (s1_last_row)
            begin
                run_total_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            run_total_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            run_total_reg <= run_total_next;
            window_reg[0] <= window_reg[3];
            window_reg[1] <= window_reg[4];
            window_reg[2] <= window_reg[5];
            window_reg[3] <= top_px;
            window_reg[4] <= mid_px;
            window_reg[5] <= s1_gray_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else if (s1_adv && emit)
        begin
            seg_valid_reg <= 1'b1;
        end
        else if (!seg_stall)
        begin
            seg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            seg_row_reg     <= s1_row_reg - ROW_W'(1);
            seg_x_start_reg <= SEG_X_W'(emit_xs);
            seg_x_end_reg   <= SEG_X_W'(emit_xe);
            seg_index_reg   <= run_total_reg;
        end
    end

    assign seg_valid   = seg_valid_reg;
    assign seg_row     = seg_row_reg;
    assign seg_x_start = seg_x_start_reg;
    assign seg_x_end   = seg_x_end_reg;
    assign seg_index   = seg_index_reg;

endmodule

// ----- sim/gray_laplacian_run_extractor_checker.sv -----
// Checker for the gray Laplacian run extractor: predicts edge runs and compares DUT results.
`timescale 1ns / 1ps

module gray_laplacian_run_extractor_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    input  logic                            pixel_stall,
    input  logic [31:0]                     pixel_data,
    input  logic                            seg_valid,
    input  logic                            seg_stall,
    input  logic [glr_pkg::SEG_ROW_W-1:0]   seg_row,
    input  logic [glr_pkg::SEG_X_W-1:0]     seg_x_start,
    input  logic [glr_pkg::SEG_X_W-1:0]     seg_x_end,
    input  logic [glr_pkg::SEG_IDX_W-1:0]   seg_index,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [glr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [glr_pkg::CFG_W-1:0]       cfg_data,
    output int                              mismatches,
    output int                              runs_pending,
    output int                              runs_checked
);
    import glr_pkg::*;

    typedef struct {
        logic [SEG_ROW_W-1:0] row;
        logic [SEG_X_W-1:0]   x_first;
        logic [SEG_X_W-1:0]   x_last;
        logic [SEG_IDX_W-1:0] index;
    } edge_run_t;

    // Runs predicted but not yet seen at the output, oldest first
    edge_run_t runs_due[$];

    // Shadow of the datapath state
    logic [PIX_W-1:0] line_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] win [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      run_from;
    int unsigned      runs_in_frame;
    bit               run_active;

    // Shadow of the configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_fmt_t         fmt_reg;
    logic [PIX_W-1:0] thresh_reg;

    task automatic report_mismatch(string msg);
        $display("%0t ns MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    function automatic int gray_of(logic [31:0] p, pix_fmt_t fmt);
        int r;
        int g;
        int b;
        if (fmt == FMT_BGRA) begin
            b = p[7:0];
            g = p[15:8];
            r = p[23:16];
        end
        else begin
            // 565 channels widened to 8 bits with truncating division
            r = int'(p[15:11]) * 255 / 31;
            g = int'(p[10:5]) * 255 / 63;
            b = int'(p[4:0]) * 255 / 31;
        end
        return (29 * b + 150 * g + 77 * r) >> 8;
    endfunction

    task automatic close_run(int unsigned row, int unsigned x_last);
        edge_run_t run;
        run.row     = SEG_ROW_W'(row);
        run.x_first = SEG_X_W'(run_from);
        run.x_last  = SEG_X_W'(x_last);
        run.index   = SEG_IDX_W'(runs_in_frame);
        runs_due    = {runs_due, run};
        if (runs_in_frame < SEG_IDX_MAX)
            runs_in_frame++;
        run_active = 1'b0;
    endtask

    // One accepted pixel: update line store, window and run tracking
    task automatic predict_pixel(logic [31:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned xi;
        int          bot;
        int          top_px;
        int          mid;
        int          sum;
        int          mag;
        bit          last_col;
        w = width_reg;
        if (w < MIN_DIM)
            w = MIN_DIM;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = height_reg;
        if (h < MIN_DIM)
            h = MIN_DIM;
        xi       = col_pos % MAX_WIDTH;
        last_col = (col_pos + 1 >= w);

        bot    = gray_of(p, fmt_reg);
        top_px = line_mem[MAX_WIDTH + xi];
        mid    = line_mem[xi];
        line_mem[MAX_WIDTH + xi] = PIX_W'(mid);
        line_mem[xi]             = PIX_W'(bot);

        // Laplacian for the pixel one row up and one column left
        if (row_pos >= 2 && col_pos >= 2) begin
            sum = int'(win[0]) + int'(win[2]) + top_px + bot
                + 4 * (int'(win[3]) + int'(win[1]) + mid + int'(win[5]))
                - 20 * int'(win[4]);
            mag = (sum < 0) ? 0 : ((sum > 255) ? 255 : sum);
            if (mag < int'(thresh_reg))
                mag = 0;
            if (mag != 0) begin
                if (!run_active) begin
                    run_active = 1'b1;
                    run_from   = col_pos - 1;
                end
                if (last_col)
                    close_run(row_pos - 1, col_pos - 1);
            end
            else if (run_active) begin
                close_run(row_pos - 1, col_pos - 2);
            end
        end

        // Window: 0..2 hold column x-2, 3..5 column x-1 (top, mid, bottom)
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = PIX_W'(top_px);
        win[4] = PIX_W'(mid);
        win[5] = PIX_W'(bot);

        if (last_col) begin
            run_active = 1'b0;
            col_pos    = 0;
            if (row_pos + 1 >= h) begin
                row_pos       = 0;
                runs_in_frame = 0;
            end
            else begin
                row_pos = row_pos + 1;
            end
        end
        else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Watch all three channels at each clock edge
    always @(posedge clk or negedge rst_n) begin
        edge_run_t want;
        if (!rst_n) begin
            for (int i = 0; i < 2 * MAX_WIDTH; i++)
                line_mem[i] = '0;
            for (int i = 0; i < 6; i++)
                win[i] = '0;
            col_pos       = 0;
            row_pos       = 0;
            run_from      = 0;
            runs_in_frame = 0;
            run_active    = 1'b0;
            width_reg     = RST_IMAGE_WIDTH;
            height_reg    = RST_IMAGE_HEIGHT;
            fmt_reg       = FMT_BGRA;
            thresh_reg    = RST_EDGE_THRESHOLD;
            runs_due.delete();
            mismatches    = 0;
            runs_checked  = 0;
            runs_pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:    width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT:   height_reg = cfg_data;
                    REG_PIXEL_FORMAT:   fmt_reg    = pix_fmt_t'(cfg_data[0]);
                    REG_EDGE_THRESHOLD: thresh_reg = cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end

            if (pixel_valid && !pixel_stall)
                predict_pixel(pixel_data);

            // Result transaction against the oldest prediction
            if (seg_valid && !seg_stall) begin
                runs_checked++;
                if (runs_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected run row %0d cols %0d..%0d index %0d",
                                              seg_row, seg_x_start, seg_x_end, seg_index));
                end
                else begin
                    want = runs_due.pop_front();
                    check_field("seg_row", seg_row, want.row);
                    check_field("seg_x_start", seg_x_start, want.x_first);
                    check_field("seg_x_end", seg_x_end, want.x_last);
                    check_field("seg_index", seg_index, want.index);
                end
            end
            runs_pending <= runs_due.size();
        end
    end

endmodule

// ----- sim/gray_laplacian_run_extractor_test.sv -----
// Testbench top: clock, reset, pixel and register stimulus, verdict for the run extractor.
`timescale 1ns / 1ps

module gray_laplacian_run_extractor_test;
    import glr_pkg::*;

    localparam bit [3:0] ALL_REGS      = '1;
    localparam bit [3:0] GEOMETRY_REGS = (4'b1 << REG_IMAGE_WIDTH) | (4'b1 << REG_IMAGE_HEIGHT);
    localparam int       GAP_PERCENT   = 34;
    localparam int       DRAIN_CYCLES  = 8;

    typedef enum int {
        ROW_NOISE,
        ROW_EXTREMES,
        ROW_FLAT,
        ROW_SPIKES
    } row_style_t;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   pixel_valid = 1'b0;
    logic [31:0]            pixel_data  = '0;
    logic                   seg_stall   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_W-1:0]       cfg_data    = '0;

    logic                   pixel_stall;
    logic                   seg_valid;
    logic [SEG_ROW_W-1:0]   seg_row;
    logic [SEG_X_W-1:0]     seg_x_start;
    logic [SEG_X_W-1:0]     seg_x_end;
    logic [SEG_IDX_W-1:0]   seg_index;
    logic                   cfg_ready;

    int                     mismatches;
    int                     runs_pending;
    int                     runs_checked;
    int                     pixels_sent = 0;
    int                     random_mark;
    bit                     gaps_on     = 1'b1;

    gray_laplacian_run_extractor u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .seg_row     (seg_row),
        .seg_x_start (seg_x_start),
        .seg_x_end   (seg_x_end),
        .seg_index   (seg_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    gray_laplacian_run_extractor_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .seg_valid    (seg_valid),
        .seg_stall    (seg_stall),
        .seg_row      (seg_row),
        .seg_x_start  (seg_x_start),
        .seg_x_end    (seg_x_end),
        .seg_index    (seg_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .runs_pending (runs_pending),
        .runs_checked (runs_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side backpressure
    always @(posedge clk)
    begin
        seg_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
    end

    // Run guard
    initial
    begin
        #10_000_000;
        $display("Timeout with %0d runs still expected", runs_pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One pixel transaction, with random gaps ahead of it
    task automatic send_pixel(logic [31:0] p);
        while (gaps_on && ($urandom_range(99) < GAP_PERCENT))
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data  <= p;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
    endtask

    // Stop sending, wait for every predicted run, then let the pipeline drain
    task automatic settle();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (runs_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(bit [3:0] regs, int w, int h, pix_fmt_t fmt, int thr);
        logic [CFG_W-1:0] value;
        for (int i = 0; i < (1 << CFG_IDX_W); i++)
        begin
            if (regs[i])
            begin
                case (cfg_reg_t'(i))
                    REG_IMAGE_WIDTH:  value = CFG_W'(w);
                    REG_IMAGE_HEIGHT: value = CFG_W'(h);
                    REG_PIXEL_FORMAT: value = CFG_W'(fmt);
                    default:          value = CFG_W'(thr);
                endcase
                cfg_valid <= 1'b1;
                cfg_index <= cfg_reg_t'(i);
                cfg_data  <= value;
                do @(posedge clk); while (!cfg_ready);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Frame with one value on the border and another inside
    task automatic send_ring(int cols, int rows, logic [31:0] ring, logic [31:0] inner);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_pixel((r == 0 || r == rows - 1 || c == 0 || c == cols - 1) ? ring : inner);
    endtask

    function automatic logic [31:0] pick_pixel(row_style_t style, logic [31:0] base);
        case (style)
            ROW_NOISE:
                return $urandom;
            ROW_EXTREMES:
                case ($urandom_range(3))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h00FF_FFFF;
                    default: return 32'hFFFF_0000;
                endcase
            ROW_FLAT:
                return base ^ ($urandom & 32'h0301_0301);
            default:
                return ($urandom_range(3) == 0) ? $urandom : base;
        endcase
    endfunction

    // Rows of random content, each row with its own character
    task automatic send_rows(int cols, int rows);
        row_style_t  style;
        logic [31:0] base;
        for (int r = 0; r < rows; r++)
        begin
            style = row_style_t'($urandom_range(3));
            base  = $urandom;
            for (int c = 0; c < cols; c++)
                send_pixel(pick_pixel(style, base));
        end
    endtask

    initial
    begin
        int w;
        int h;
        int frames;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single edge pixel at full scale, both formats, thresholds 0 and 255
        configure(ALL_REGS, 3, 3, FMT_BGRA, 0);
        send_ring(3, 3, 32'hFFFF_FFFF, 32'h0000_0000);
        settle();
        configure(ALL_REGS, 3, 3, FMT_RGB565, 255);
        send_ring(3, 3, 32'h0000_FFFF, 32'hFFFF_0000);
        settle();
        // Weak edges kept by a zero threshold; alpha bits must not matter
        configure(ALL_REGS, 4, 3, FMT_BGRA, 0);
        send_ring(4, 3, 32'h0001_0101, 32'hFF00_0000);
        settle();

        // Format and threshold kept from before, small geometry
        configure(GEOMETRY_REGS, 16, 8, FMT_BGRA, 0);
        send_rows(16, 16);
        settle();
        configure(ALL_REGS, 5, 4, FMT_RGB565, 0);
        send_rows(5, 12);
        settle();
        // Width and height below range act as three
        configure(ALL_REGS, 1, 2, FMT_BGRA, 255);
        send_rows(3, 12);
        settle();

        // Longer rows, no idling on either side
        gaps_on = 1'b0;
        configure(ALL_REGS, 64, 3, FMT_RGB565, 40);
        send_rows(64, 3);
        settle();
        configure(ALL_REGS, 0, 1, FMT_BGRA, 100);
        send_rows(3, 6);
        settle();
        gaps_on = 1'b1;

        // Tall narrow frame
        configure(ALL_REGS, 3, 40, FMT_BGRA, 128);
        send_rows(3, 40);
        settle();

        // Geometry shrinks at a row boundary inside a frame; next row ends it
        configure(ALL_REGS, 12, 10, FMT_RGB565, 60);
        send_rows(12, 5);
        settle();
        configure(GEOMETRY_REGS, 8, 3, FMT_RGB565, 60);
        send_rows(8, 7);
        settle();

        // Random small frames under random settings
        random_mark = pixels_sent;
        while (pixels_sent - random_mark < 220)
        begin
            w      = $urandom_range(24, MIN_DIM);
            h      = $urandom_range(9, MIN_DIM);
            frames = $urandom_range(3, 1);
            configure(ALL_REGS, w, h, pix_fmt_t'($urandom_range(1)), $urandom_range(255));
            send_rows(w, h * frames);
            settle();
        end

        repeat (20) @(posedge clk);
        $display("Summary: %0d pixels in BGRA and RGB565, widths 3..64, heights 3..40",
                 pixels_sent);
        $display("Summary: %0d edge runs compared, thresholds 0..255, mid-frame resize",
                 runs_checked);
        if (runs_pending != 0)
            $display("%0d expected runs never arrived", runs_pending);
        if (mismatches == 0 && runs_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
